// ===== hdl/hla_pkg.sv =====
package hla_pkg;

    localparam int SIZE_W = 17;
    localparam int ADDR_W = 16;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;
    localparam logic [1:0] POL_SPARE = 2'd3;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_SHIFTL = 2'd2,
        CMD_SHIFTR = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      wr_en;
    } cell_ctl_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_APPLY  = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_RESP   = 5'b10000
    } state_t;

endpackage

// ===== hdl/hole_list_allocator_top.sv =====
// Channel   Direction  Ports
// s_        in         s_valid s_ready s_opcode s_block_size s_free_address
// m_        out        m_valid m_ready m_granted_address m_status
// cfg       in         cfg_wr_en cfg_wr_data (fit_policy)
// A transaction scans one hole per cycle in the scan state, then passes through the
// apply state, the shift state for the cell row and the response state, and the
// block returns to the idle state before the next transaction is taken.
// Reset leaves one hole covering the memory and first fit selected.
// The next transaction is taken once the response has been accepted.
module hole_list_allocator_top #(
    parameter int MAX_HOLES = 16,
    parameter int MEM_WORDS = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [16:0] s_block_size,
    input  logic [15:0] s_free_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_granted_address,
    output logic [1:0]  m_status,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data
);

    localparam int BASE_W = $clog2(MEM_WORDS);
    localparam int LEN_W  = BASE_W + 1;
    localparam int IDX_W  = $clog2(MAX_HOLES);
    localparam int CNT_W  = $clog2(MAX_HOLES + 1);
    localparam int EXT_W  = LEN_W + 1;
    localparam logic [LEN_W-1:0] MEM_LEN = LEN_W'(MEM_WORDS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_HOLES);

    hla_pkg::state_t state_reg, state_next;
    logic [1:0]        pol_reg;
    logic              op_reg;
    logic [LEN_W-1:0]  sz_reg;
    logic [BASE_W-1:0] p_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  i_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  pick_reg;
    logic [LEN_W-1:0]  key_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [BASE_W-1:0] lbase_reg, rbase_reg;
    logic [LEN_W-1:0]  llen_reg, rlen_reg;
    logic [15:0]       addr_reg;
    logic [1:0]        st_reg;
    logic [IDX_W-1:0]  sh_from_reg;
    hla_pkg::cell_cmd_t sh_cmd_reg;
    logic              sh_en_reg;

    logic [BASE_W-1:0] cb [MAX_HOLES];
    logic [LEN_W-1:0]  cl [MAX_HOLES];
    hla_pkg::cell_ctl_t ctl [MAX_HOLES];
    logic [MAX_HOLES-1:0] ld_en;
    logic [BASE_W-1:0] ld_base;
    logic [LEN_W-1:0]  ld_len;

    logic [IDX_W-1:0]  i_idx;
    logic [BASE_W-1:0] cur_b;
    logic [LEN_W-1:0]  cur_l;

    assign i_idx = i_reg[IDX_W-1:0];
    assign cur_b = cb[i_idx];
    assign cur_l = cl[i_idx];

    genvar g;
    generate
        for (g = 0; g < MAX_HOLES; g++) begin : g_cell
            logic [BASE_W-1:0] lb, rb;
            logic [LEN_W-1:0]  ll, rl;
            if (g == 0) begin : g_l0
                assign lb = '0;
                assign ll = '0;
            end else begin : g_ln
                assign lb = cb[g-1];
                assign ll = cl[g-1];
            end
            if (g == MAX_HOLES - 1) begin : g_rl
                assign rb = '0;
                assign rl = '0;
            end else begin : g_rn
                assign rb = cb[g+1];
                assign rl = cl[g+1];
            end
            always_comb begin
                ctl[g].cmd   = hla_pkg::CMD_HOLD;
                ctl[g].wr_en = 1'b0;
                if (ld_en[g]) begin
                    ctl[g].cmd   = hla_pkg::CMD_LOAD;
                    ctl[g].wr_en = 1'b1;
                end else if (sh_en_reg && state_reg == hla_pkg::S_SHIFT) begin
                    if (sh_cmd_reg == hla_pkg::CMD_SHIFTL
                        && IDX_W'(g) >= sh_from_reg) begin
                        ctl[g].cmd   = hla_pkg::CMD_SHIFTL;
                        ctl[g].wr_en = 1'b1;
                    end else if (sh_cmd_reg == hla_pkg::CMD_SHIFTR
                        && IDX_W'(g) > sh_from_reg) begin
                        ctl[g].cmd   = hla_pkg::CMD_SHIFTR;
                        ctl[g].wr_en = 1'b1;
                    end
                end
            end
            hla_cell #(
                .BASE_W(BASE_W), .LEN_W(LEN_W),
                .RST_BASE('0),
                .RST_LEN(g == 0 ? MEM_LEN : '0)
            ) u_cell (
                .aclk(aclk), .aresetn(aresetn), .ctl(ctl[g]),
                .left_base(lb), .left_len(ll),
                .right_base(rb), .right_len(rl),
                .load_base(ld_base), .load_len(ld_len),
                .base(cb[g]), .len(cl[g])
            );
        end
    endgenerate

    function automatic logic [LEN_W-1:0] sat(input logic [EXT_W-1:0] s);
        sat = (s > EXT_W'(MEM_LEN)) ? MEM_LEN : s[LEN_W-1:0];
    endfunction

    // scan-step decisions
    logic in_range;
    logic fits;
    logic [LEN_W-1:0] slack;
    logic take;
    always_comb begin
        in_range = i_reg < cnt_reg;
        fits  = cur_l >= sz_reg;
        slack = cur_l - sz_reg;
        take  = 1'b0;
        case (pol_reg)
            hla_pkg::POL_BEST:  take = fits && (!found_reg || slack <= key_reg);
            hla_pkg::POL_WORST: take = !found_reg || cur_l >= key_reg;
            default:            take = fits && !found_reg;
        endcase
    end

    logic [EXT_W-1:0] fend;
    logic [EXT_W-1:0] lend;
    logic left_m, right_m, has_l, has_r;
    assign fend  = EXT_W'(p_reg) + EXT_W'(sz_reg);
    assign has_l = pos_reg != '0;
    assign has_r = pos_reg < cnt_reg;
    assign lend  = EXT_W'(lbase_reg) + EXT_W'(llen_reg);
    assign left_m  = has_l && lend == EXT_W'(p_reg);
    assign right_m = has_r && EXT_W'(rbase_reg) == fend;

    logic [IDX_W-1:0] pos_idx, posm1_idx;
    assign pos_idx   = pos_reg[IDX_W-1:0];
    assign posm1_idx = IDX_W'(pos_reg - CNT_W'(1));

    logic ok_alloc;
    assign ok_alloc = found_reg && !(pol_reg == hla_pkg::POL_WORST && key_reg < sz_reg);

    always_comb begin
        ld_en   = '0;
        ld_base = '0;
        ld_len  = '0;
        if (state_reg == hla_pkg::S_APPLY) begin
            if (op_reg == hla_pkg::OP_ALLOC) begin
                if (ok_alloc && cl[pick_reg] != sz_reg) begin
                    ld_en[pick_reg] = 1'b1;
                    ld_base = cb[pick_reg] + sz_reg[BASE_W-1:0];
                    ld_len  = cl[pick_reg] - sz_reg;
                end
            end else if (sz_reg != '0 && fend <= EXT_W'(MEM_LEN)) begin
                if (left_m) begin
                    ld_en[posm1_idx] = 1'b1;
                    ld_base = lbase_reg;
                    ld_len  = right_m
                        ? sat(EXT_W'(sat(EXT_W'(llen_reg) + EXT_W'(sz_reg)))
                              + EXT_W'(rlen_reg))
                        : sat(EXT_W'(llen_reg) + EXT_W'(sz_reg));
                end else if (right_m) begin
                    ld_en[pos_idx] = 1'b1;
                    ld_base = p_reg;
                    ld_len  = sat(EXT_W'(rlen_reg) + EXT_W'(sz_reg));
                end
            end
        end else if (state_reg == hla_pkg::S_SHIFT && sh_en_reg
                     && sh_cmd_reg == hla_pkg::CMD_SHIFTR) begin
            ld_en[sh_from_reg] = 1'b1;
            ld_base = p_reg;
            ld_len  = sz_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hla_pkg::S_IDLE:  if (s_valid) state_next = hla_pkg::S_SCAN;
            hla_pkg::S_SCAN:  if (!in_range) state_next = hla_pkg::S_APPLY;
            hla_pkg::S_APPLY: state_next = hla_pkg::S_SHIFT;
            hla_pkg::S_SHIFT: state_next = hla_pkg::S_RESP;
            hla_pkg::S_RESP:  if (m_ready) state_next = hla_pkg::S_IDLE;
            default:          state_next = hla_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hla_pkg::S_IDLE;
            pol_reg   <= hla_pkg::POL_FIRST;
            cnt_reg   <= CNT_W'(1);
            sh_en_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) pol_reg <= cfg_wr_data;
            case (state_reg)
                hla_pkg::S_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= s_opcode;
                        sz_reg    <= LEN_W'(s_block_size);
                        p_reg     <= BASE_W'(s_free_address);
                        i_reg     <= '0;
                        found_reg <= 1'b0;
                        pick_reg  <= '0;
                        key_reg   <= '0;
                        pos_reg   <= '0;
                        sh_en_reg <= 1'b0;
                    end
                end
                hla_pkg::S_SCAN: begin
                    if (in_range) begin
                        i_reg <= i_reg + CNT_W'(1);
                        if (op_reg == hla_pkg::OP_ALLOC) begin
                            if (take) begin
                                found_reg <= 1'b1;
                                pick_reg  <= i_idx;
                                key_reg   <= (pol_reg == hla_pkg::POL_BEST) ? slack : cur_l;
                            end
                        end else if (cur_b <= p_reg && pos_reg == i_reg) begin
                            pos_reg   <= i_reg + CNT_W'(1);
                            lbase_reg <= cur_b;
                            llen_reg  <= cur_l;
                        end else if (pos_reg == i_reg && !found_reg) begin
                            found_reg <= 1'b1;
                            rbase_reg <= cur_b;
                            rlen_reg  <= cur_l;
                        end
                    end
                end
                hla_pkg::S_APPLY: begin
                    addr_reg <= '0;
                    st_reg   <= hla_pkg::ST_OK;
                    if (op_reg == hla_pkg::OP_ALLOC) begin
                        if (sz_reg == '0 || !ok_alloc) begin
                            st_reg <= hla_pkg::ST_NO_SPACE;
                        end else begin
                            addr_reg <= 16'(cb[pick_reg]);
                            if (cl[pick_reg] == sz_reg) begin
                                sh_en_reg   <= 1'b1;
                                sh_cmd_reg  <= hla_pkg::CMD_SHIFTL;
                                sh_from_reg <= pick_reg;
                                cnt_reg     <= cnt_reg - CNT_W'(1);
                            end
                        end
                    end else if (sz_reg != '0 && fend <= EXT_W'(MEM_LEN)) begin
                        if (left_m && right_m) begin
                            sh_en_reg   <= 1'b1;
                            sh_cmd_reg  <= hla_pkg::CMD_SHIFTL;
                            sh_from_reg <= pos_idx;
                            cnt_reg     <= cnt_reg - CNT_W'(1);
                        end else if (!left_m && !right_m) begin
                            if (cnt_reg >= MAX_CNT) begin
                                st_reg <= hla_pkg::ST_FULL;
                            end else begin
                                sh_en_reg   <= 1'b1;
                                sh_cmd_reg  <= hla_pkg::CMD_SHIFTR;
                                sh_from_reg <= pos_idx;
                                cnt_reg     <= cnt_reg + CNT_W'(1);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign s_ready           = state_reg == hla_pkg::S_IDLE;
    assign m_valid           = state_reg == hla_pkg::S_RESP;
    assign m_granted_address = addr_reg;
    assign m_status          = st_reg;

endmodule

// ===== hdl/hla_cell.sv =====
module hla_cell #(
    parameter int BASE_W = 24,
    parameter int LEN_W  = 25,
    parameter logic [BASE_W-1:0] RST_BASE = '0,
    parameter logic [LEN_W-1:0]  RST_LEN  = '0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  hla_pkg::cell_ctl_t ctl,
    input  logic [BASE_W-1:0] left_base,
    input  logic [LEN_W-1:0]  left_len,
    input  logic [BASE_W-1:0] right_base,
    input  logic [LEN_W-1:0]  right_len,
    input  logic [BASE_W-1:0] load_base,
    input  logic [LEN_W-1:0]  load_len,
    output logic [BASE_W-1:0] base,
    output logic [LEN_W-1:0]  len
);

    logic [BASE_W-1:0] base_reg, base_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    always_comb begin
        base_next = base_reg;
        len_next  = len_reg;
        if (ctl.wr_en) begin
            case (ctl.cmd)
                hla_pkg::CMD_LOAD: begin
                    base_next = load_base;
                    len_next  = load_len;
                end
                hla_pkg::CMD_SHIFTL: begin
                    base_next = right_base;
                    len_next  = right_len;
                end
                hla_pkg::CMD_SHIFTR: begin
                    base_next = left_base;
                    len_next  = left_len;
                end
                default: begin
                    base_next = base_reg;
                    len_next  = len_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= RST_BASE;
            len_reg  <= RST_LEN;
        end else begin
            base_reg <= base_next;
            len_reg  <= len_next;
        end
    end

    assign base = base_reg;
    assign len  = len_reg;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int HOLES = 16;
    localparam int WORDS = 65536;
    localparam int LIMIT = 2000000;

    typedef struct {
        logic        opcode;
        logic [16:0] size;
        logic [15:0] addr;
    } request_t;

    typedef struct {
        logic [15:0] granted;
        logic [1:0]  status;
    } grant_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = 1'b0;
    logic [16:0] s_block_size = '0;
    logic [15:0] s_free_address = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_granted_address;
    logic [1:0]  m_status;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_data = '0;

    request_t pending_q[$];
    grant_t   grant_q[$];
    int       errors = 0;
    int       cycles = 0;
    int       send_idle = 0;
    int       recv_stall = 0;
    int       hold_off = 0;
    logic     hold_req = 1'b0;
    logic     hold_seen = 1'b0;

    int unsigned  hbase[HOLES];
    int unsigned  hlen[HOLES];
    int unsigned  hcount;
    logic [1:0]   policy;

    hole_list_allocator_top #(.MAX_HOLES(HOLES), .MEM_WORDS(WORDS)) DUT (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned sat_add(int unsigned a, int unsigned b);
        return (a + b > WORDS) ? WORDS : a + b;
    endfunction

    function automatic void remove_hole(int unsigned k);
        for (int unsigned i = k; i + 1 < hcount; i++) begin
            hbase[i] = hbase[i + 1];
            hlen[i] = hlen[i + 1];
        end
        hcount--;
    endfunction

    function automatic grant_t predict_grant(request_t r);
        grant_t g;
        int unsigned sz, p, pick, slack, pos;
        bit found, left, right;
        g.granted = '0;
        g.status = hla_pkg::ST_OK;
        sz = 32'(r.size);
        p = 32'(r.addr);
        pick = 0;
        found = 0;
        slack = 0;
        if (r.opcode == hla_pkg::OP_ALLOC) begin
            if (sz != 0) begin
                if (policy == hla_pkg::POL_BEST) begin
                    for (int unsigned i = 0; i < hcount; i++)
                        if (hlen[i] >= sz && (!found || hlen[i] - sz <= slack)) begin
                            slack = hlen[i] - sz;
                            pick = i;
                            found = 1;
                        end
                end else if (policy == hla_pkg::POL_WORST) begin
                    for (int unsigned i = 0; i < hcount; i++)
                        if (!found || hlen[i] >= slack) begin
                            slack = hlen[i];
                            pick = i;
                            found = 1;
                        end
                    if (found && slack < sz) found = 0;
                end else begin
                    for (int unsigned i = 0; i < hcount && !found; i++)
                        if (hlen[i] >= sz) begin
                            pick = i;
                            found = 1;
                        end
                end
            end
            if (!found) begin
                g.status = hla_pkg::ST_NO_SPACE;
            end else begin
                g.granted = hbase[pick][15:0];
                if (hlen[pick] == sz) begin
                    remove_hole(pick);
                end else begin
                    hbase[pick] += sz;
                    hlen[pick] -= sz;
                end
            end
        end else if (sz != 0 && p + sz <= WORDS) begin
            pos = 0;
            while (pos < hcount && hbase[pos] <= p) pos++;
            left = pos > 0 && hbase[pos - 1] + hlen[pos - 1] == p;
            right = pos < hcount && hbase[pos] == p + sz;
            if (left && right) begin
                hlen[pos - 1] = sat_add(sat_add(hlen[pos - 1], sz), hlen[pos]);
                remove_hole(pos);
            end else if (left) begin
                hlen[pos - 1] = sat_add(hlen[pos - 1], sz);
            end else if (right) begin
                hbase[pos] = p;
                hlen[pos] = sat_add(hlen[pos], sz);
            end else if (hcount >= HOLES) begin
                g.status = hla_pkg::ST_FULL;
            end else begin
                for (int unsigned i = hcount; i > pos; i--) begin
                    hbase[i] = hbase[i - 1];
                    hlen[i] = hlen[i - 1];
                end
                hbase[pos] = p;
                hlen[pos] = sz;
                hcount++;
            end
        end
        return g;
    endfunction

    function automatic void add_request(logic op, int unsigned sz, int unsigned ad);
        request_t r;
        r.opcode = op;
        r.size = sz[16:0];
        r.addr = ad[15:0];
        pending_q = {pending_q, r};
    endfunction

    function automatic void add_random(int n);
        int unsigned k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 40)
                add_request(hla_pkg::OP_ALLOC, $urandom_range(1, 4096), $urandom);
            else if (k < 75)
                add_request(hla_pkg::OP_FREE, $urandom_range(1, 2048),
                            $urandom_range(0, 16383));
            else if (k < 85)
                add_request(hla_pkg::OP_FREE, $urandom_range(0, 131071), $urandom);
            else if (k < 95)
                add_request(hla_pkg::OP_ALLOC, $urandom_range(0, 131071), $urandom);
            else
                add_request(hla_pkg::OP_FREE, $urandom_range(1, 16),
                            $urandom_range(0, 255) * 64);
        end
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // hold off the receiver for a long stretch
    always @(posedge aclk) begin
        if (hold_req && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_off <= 300;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                grant_q = {grant_q, predict_grant(pending_q.pop_front())};
            end
            if (!s_valid || s_ready) begin
                if (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
                    s_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    s_valid <= 1'b1;
                    s_opcode <= pending_q[0].opcode;
                    s_block_size <= pending_q[0].size;
                    s_free_address <= pending_q[0].addr;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        grant_t exp_g;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (grant_q.size() == 0) begin
                    $error("unexpected transaction: granted_address %0h status %0d",
                           m_granted_address, m_status);
                    errors++;
                end else begin
                    exp_g = grant_q.pop_front();
                    if (m_granted_address !== exp_g.granted) begin
                        $error("granted_address: expected %0h actual %0h",
                               exp_g.granted, m_granted_address);
                        errors++;
                    end
                    if (m_status !== exp_g.status) begin
                        $error("status: expected %0d actual %0d", exp_g.status, m_status);
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= !(recv_stall > 0 && $urandom_range(0, 99) < recv_stall);
            end
        end
    end

    task automatic drain();
        while (pending_q.size() > 0 || s_valid || grant_q.size() > 0)
            @(posedge aclk);
        repeat (2 * HOLES + 10) @(posedge aclk);
    endtask

    task automatic set_policy(logic [1:0] p);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= p;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        policy = p;
    endtask

    initial begin
        hbase = '{default: 0};
        hlen = '{default: 0};
        hbase[0] = 0;
        hlen[0] = WORDS;
        hcount = 1;
        policy = hla_pkg::POL_FIRST;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes, exact fit, empty table, merges, full table
        add_request(hla_pkg::OP_ALLOC, 0, 16'hffff);
        add_request(hla_pkg::OP_ALLOC, 65537, 0);
        add_request(hla_pkg::OP_ALLOC, 131071, 0);
        add_request(hla_pkg::OP_ALLOC, 65536, 0);
        add_request(hla_pkg::OP_ALLOC, 1, 0);
        add_request(hla_pkg::OP_FREE, 0, 100);
        add_request(hla_pkg::OP_FREE, 10, 65530);
        add_request(hla_pkg::OP_FREE, 131071, 16'hffff);
        add_request(hla_pkg::OP_FREE, 1, 65535);
        add_request(hla_pkg::OP_FREE, 100, 200);
        add_request(hla_pkg::OP_FREE, 100, 400);
        add_request(hla_pkg::OP_FREE, 100, 300);
        add_request(hla_pkg::OP_FREE, 100, 100);
        add_request(hla_pkg::OP_FREE, 50, 1000);
        add_request(hla_pkg::OP_FREE, 50, 1000);
        for (int i = 0; i < 17; i++)
            add_request(hla_pkg::OP_FREE, 1, 2000 + 4 * i);
        add_request(hla_pkg::OP_ALLOC, 1, 0);
        add_request(hla_pkg::OP_ALLOC, 65536, 0);
        drain();

        set_policy(hla_pkg::POL_BEST);
        recv_stall = 57;
        add_random(120);
        drain();

        set_policy(hla_pkg::POL_WORST);
        send_idle = 57;
        recv_stall = 0;
        add_random(120);
        drain();

        set_policy(hla_pkg::POL_SPARE);
        send_idle = 31;
        recv_stall = 31;
        add_random(120);
        drain();

        set_policy(hla_pkg::POL_FIRST);
        send_idle = 0;
        recv_stall = 0;
        hold_req = 1'b1;
        add_random(120);
        drain();

        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
